>>> design/hua_pkg.sv
// Shared types, constants and rounding helper for the Hadamard unitary accumulator.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package hua_pkg;

  localparam int MAX_QUBITS = 5;

  localparam int ELEM_W = 18;
  localparam int SUM_W  = 19;
  localparam int PROD_W = 36;

  localparam logic signed [ELEM_W-1:0] ONE_Q16       = 18'sd65536;
  localparam logic signed [ELEM_W-1:0] NEG_ONE_Q16   = -18'sd65536;
  localparam logic signed [16:0]       HALF_ROOT_Q16 = 17'sd46341;

  typedef enum logic [1:0] {
    KIND_APPLY = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic read_issue;
    logic capture;
    logic issue;
    logic qnext;
  } hua_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       q_end;
    logic       q_hit;
    logic       sweep_last;
    logic       pipe_idle;
  } hua_sts_t;

  // round to nearest (ties up) from Q.32 to Q1.16, saturate to +/-1.0
  function automatic logic signed [ELEM_W-1:0] rnd_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0] t;
    logic signed [20:0]     v;
    logic signed [ELEM_W-1:0] res;
    t = {p[PROD_W-1], p} + 37'sd32768;
    v = t[PROD_W:16];
    if (v > 21'sd65536) begin
      res = ONE_Q16;
    end else if (v < -21'sd65536) begin
      res = NEG_ONE_Q16;
    end else begin
      res = v[ELEM_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> design/hua_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hua_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> design/hua_ctrl.sv
// Sequencing state machine: item dispatch, qubit passes, drain, read capture, result strobe.
// Depends on hua_pkg for the command/status structs and item kinds.
`default_nettype none

module hua_ctrl import hua_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire hua_sts_t sts,
  output hua_cmd_t      cmd,
  output logic          busy,
  output logic          done
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_QSEL,
    S_RUN,
    S_DRAIN,
    S_RCAP,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, done_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.kind)
          KIND_APPLY: state_nxt = S_QSEL;
          KIND_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = S_FINISH;
          end
          KIND_READ: begin
            cmd.read_issue = 1'b1;
            state_nxt      = S_RCAP;
          end
          default: state_nxt = S_FINISH;
        endcase
      end
      S_QSEL: begin
        priority if (sts.q_end) begin
          state_nxt = S_FINISH;
        end else if (sts.q_hit) begin
          state_nxt = S_RUN;
        end else begin
          cmd.qnext = 1'b1;
        end
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.pipe_idle) begin
          cmd.qnext = 1'b1;
          state_nxt = S_QSEL;
        end
      end
      S_RCAP: begin
        cmd.capture = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_FINISH: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == S_FINISH);
      if (state_r == S_IDLE && start) begin
        busy_r <= 1'b1;
      end else if (state_r == S_FINISH) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;

endmodule

`default_nettype wire

>>> design/hua_dp.sv
// Datapath: item registers, qubit count, row-valid bits, pair address walker,
// butterfly pipeline and the matrix RAM. Depends on hua_pkg and hua_ram.
`default_nettype none

module hua_dp import hua_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire hua_cmd_t                 cmd,
  output hua_sts_t                      sts,
  input  wire logic                     cfg_we,
  input  wire logic [2:0]               cfg_qubit_count,
  input  wire logic [1:0]               in_kind,
  input  wire logic [4:0]               in_qubit_mask,
  input  wire logic [4:0]               in_row_index,
  input  wire logic [4:0]               in_column_index,
  output logic signed [ELEM_W-1:0]      out_element_value,
  output logic [1:0]                    out_kind_done
);

  localparam int MW    = MAX_QUBITS;
  localparam int NW    = $clog2(MAX_QUBITS + 1);
  localparam int AW    = 2 * MW;
  localparam int SIDE  = 1 << MW;
  localparam int DEPTH = 1 << AW;

  logic [NW-1:0]  n_r, q_r, pos;
  logic [1:0]     kind_r;
  logic [4:0]     mask_r, row_r, col_r;
  logic [MW-1:0]  rowc_r, k_r;
  logic           phase_r;
  logic [SIDE-1:0] row_valid_r;
  logic signed [ELEM_W-1:0] res_r;

  logic [MW-1:0]  low_m, half_m1, side_m1, col_a, col_b, col_sel, rd_row, rd_col;
  logic           k_last, row_last, in_rng, rd_en;
  logic [AW-1:0]  rd_addr;
  logic [ELEM_W-1:0] rd_word;
  logic signed [ELEM_W-1:0] cur_val;

  logic           s1_vld_r, s1_ph_r, s1_last_r, s1_rowv_r, s1_diag_r;
  logic [AW-1:0]  s1_addr_r;
  logic signed [ELEM_W-1:0] a_r;
  logic [AW-1:0]  a_addr_r;

  logic           s2_vld_r, s2_last_r;
  logic signed [SUM_W-1:0] sum_r, dif_r;
  logic [AW-1:0]  s2_addra_r, s2_addrb_r;

  logic           s3_vld_r, s3_last_r;
  logic signed [PROD_W-1:0] ps_r, pd_r;
  logic [AW-1:0]  s3_addra_r, s3_addrb_r;

  logic           s4_vld_r, s4_last_r;
  logic [AW-1:0]  s4_addrb_r;

  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [ELEM_W-1:0] wr_data;

  always_comb begin
    pos      = n_r - NW'(1) - q_r;
    low_m    = (MW'(1) << pos) - MW'(1);
    half_m1  = (MW'(1) << (n_r - NW'(1))) - MW'(1);
    side_m1  = (MW'(1) << n_r) - MW'(1);
    k_last   = (k_r == half_m1);
    row_last = (rowc_r == side_m1);
    col_a    = ((k_r & ~low_m) << 1) | (k_r & low_m);
    col_b    = col_a | (MW'(1) << pos);
    col_sel  = phase_r ? col_b : col_a;
    rd_row   = cmd.read_issue ? MW'(row_r) : rowc_r;
    rd_col   = cmd.read_issue ? MW'(col_r) : col_sel;
    rd_addr  = {rd_row, rd_col};
    rd_en    = cmd.issue | cmd.read_issue;
    in_rng   = ((row_r >> n_r) == 5'd0) && ((col_r >> n_r) == 5'd0);
    cur_val  = s1_rowv_r ? $signed(rd_word) : (s1_diag_r ? ONE_Q16 : '0);
  end

  always_comb begin
    sts.kind       = kind_r;
    sts.q_end      = (q_r >= n_r);
    sts.q_hit      = |(mask_r & (5'(1) << q_r));
    sts.sweep_last = phase_r && k_last && row_last;
    sts.pipe_idle  = !(s1_vld_r || s2_vld_r || s3_vld_r || s4_vld_r);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= NW'(1);
      q_r         <= '0;
      rowc_r      <= '0;
      k_r         <= '0;
      phase_r     <= 1'b0;
      row_valid_r <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_qubit_count == 3'd0) begin
          n_r <= NW'(1);
        end else if (32'(cfg_qubit_count) > MAX_QUBITS) begin
          n_r <= NW'(MAX_QUBITS);
        end else begin
          n_r <= NW'(cfg_qubit_count);
        end
      end

      if (cmd.load) begin
        q_r     <= '0;
        rowc_r  <= '0;
        k_r     <= '0;
        phase_r <= 1'b0;
      end else begin
        if (cmd.qnext) begin
          q_r <= q_r + NW'(1);
        end
        if (cmd.issue) begin
          phase_r <= ~phase_r;
          if (phase_r) begin
            if (k_last) begin
              k_r    <= '0;
              rowc_r <= row_last ? '0 : rowc_r + MW'(1);
            end else begin
              k_r <= k_r + MW'(1);
            end
          end
        end
      end

      if (cfg_we || cmd.clear) begin
        row_valid_r <= '0;
      end else if (s4_vld_r && s4_last_r) begin
        row_valid_r[s4_addrb_r[AW-1:MW]] <= 1'b1;
      end

      s1_vld_r <= cmd.issue;
      s2_vld_r <= s1_vld_r && s1_ph_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      mask_r <= in_qubit_mask;
      row_r  <= in_row_index;
      col_r  <= in_column_index;
      res_r  <= '0;
    end else if (cmd.capture) begin
      res_r <= in_rng ? cur_val : '0;
    end

    if (rd_en) begin
      s1_ph_r   <= phase_r;
      s1_last_r <= k_last;
      s1_rowv_r <= row_valid_r[rd_row];
      s1_diag_r <= (rd_row == rd_col);
      s1_addr_r <= rd_addr;
    end

    if (s1_vld_r && !s1_ph_r) begin
      a_r      <= cur_val;
      a_addr_r <= s1_addr_r;
    end

    if (s1_vld_r && s1_ph_r) begin
      sum_r      <= SUM_W'(a_r) + SUM_W'(cur_val);
      dif_r      <= SUM_W'(a_r) - SUM_W'(cur_val);
      s2_addra_r <= a_addr_r;
      s2_addrb_r <= s1_addr_r;
      s2_last_r  <= s1_last_r;
    end

    if (s2_vld_r) begin
      ps_r       <= PROD_W'(sum_r) * PROD_W'(HALF_ROOT_Q16);
      pd_r       <= PROD_W'(dif_r) * PROD_W'(HALF_ROOT_Q16);
      s3_addra_r <= s2_addra_r;
      s3_addrb_r <= s2_addrb_r;
      s3_last_r  <= s2_last_r;
    end

    if (s3_vld_r) begin
      s4_addrb_r <= s3_addrb_r;
      s4_last_r  <= s3_last_r;
    end
  end

  always_comb begin
    wr_en   = s3_vld_r | s4_vld_r;
    wr_addr = s3_vld_r ? s3_addra_r : s4_addrb_r;
    wr_data = s3_vld_r ? rnd_sat(ps_r) : rnd_sat(pd_r);
  end

  hua_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH)
  ) u_matrix (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  assign out_element_value = res_r;
  assign out_kind_done     = kind_r;

endmodule

`default_nettype wire

>>> design/hadamard_unitary_accumulator_top.sv
// Top level of the Hadamard unitary accumulator: controller, datapath, port glue.
// Depends on hua_pkg, hua_ctrl, hua_dp (which holds hua_ram).
//
// An item is taken when start is high and busy is low; its single result appears on
// out_element_value / out_kind_done for one cycle with out_strobe high and cannot be
// stalled. An apply makes one pass for each masked qubit q < n: each pass walks 2^n rows
// by 2^(n-1) butterfly pairs, and the matrix memory's one read port fetches one element
// per cycle; each pass then waits for its last pair to be written back. A new item may
// be accepted in the strobe cycle. After reset or a qubit_count write the matrix reads
// as identity at once, with no clearing pass. cfg_ready is low while an item is in
// progress.
`default_nettype none

module hadamard_unitary_accumulator_top import hua_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_kind,
  input  wire logic [4:0]         in_qubit_mask,
  input  wire logic [4:0]         in_row_index,
  input  wire logic [4:0]         in_column_index,
  output logic                    out_strobe,
  output logic signed [17:0]      out_element_value,
  output logic [1:0]              out_kind_done,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_qubit_count
);

  hua_cmd_t cmd;
  hua_sts_t sts;
  logic     cfg_we;

  assign cfg_ready = ~busy;
  assign cfg_we    = cfg_valid & cfg_ready;

  hua_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (out_strobe)
  );

  hua_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_qubit_count   (cfg_qubit_count),
    .in_kind           (in_kind),
    .in_qubit_mask     (in_qubit_mask),
    .in_row_index      (in_row_index),
    .in_column_index   (in_column_index),
    .out_element_value (out_element_value),
    .out_kind_done     (out_kind_done)
  );

endmodule

`default_nettype wire
